// File: rtl/core/lftc_pkg.sv
// Package for the line follow turn controller.
// Holds mode encoding, sequencer states and fixed constants; no dependencies.
package lftc_pkg;

    typedef enum logic [2:0] {
        MODE_TRACK   = 3'd0,
        MODE_ADVANCE = 3'd1,
        MODE_BLIND   = 3'd2,
        MODE_LEFT    = 3'd3,
        MODE_RIGHT   = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_FINISH,
        ST_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        REG_PROP  = 3'd0,
        REG_INTEG = 3'd1,
        REG_DERIV = 3'd2,
        REG_BASE  = 3'd3,
        REG_MAX   = 3'd4,
        REG_BLIND = 3'd5,
        REG_LCOMP = 3'd6,
        REG_TURN  = 3'd7
    } reg_idx_t;

    localparam int MIN_DWELL_TICKS = 100;
    localparam int CONFIRM_TICKS   = 3;
    localparam int ADV_RUN_TICKS   = 80;
    localparam int TURN_ANGLE      = 5312;
    localparam int TURN_TOLERANCE  = 320;
    localparam int DEG180          = 11520;
    localparam int DEG360          = 23040;
    localparam int INTEG_LIMIT     = 25600;
    localparam int DRIVE_LIMIT     = 1023;

    // Signed weight of one line sensor.
    function automatic logic signed [3:0] line_weight(input logic [2:0] idx);
        case (idx)
            3'd0: line_weight = -4'sd7;
            3'd1: line_weight = -4'sd5;
            3'd2: line_weight = -4'sd3;
            3'd3: line_weight = -4'sd1;
            3'd4: line_weight = 4'sd1;
            3'd5: line_weight = 4'sd3;
            3'd6: line_weight = 4'sd5;
            default: line_weight = 4'sd7;
        endcase
    endfunction

endpackage

// File: rtl/core/line_follow_turn_controller.sv
// Top level of the line follow turn controller: mode machine, track PID and turns.
// Depends on lftc_pkg.
//
// One request is one control tick: a line sensor byte and a yaw go in, one motor
// command comes out. A tick in track mode with a black sensor goes from ST_FINISH
// through a 13-step restoring divider that forms the line error, then one shared
// 18x26 multiplier forms the three PID products in turn before ST_OUT. A track
// tick with no black sensor skips the divider; other modes go from ST_FINISH
// straight to ST_OUT. The block takes no new request until the result has been
// taken, and is ready again in the cycle after that.
module line_follow_turn_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] sensor_bits, [22:8] yaw_now, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [10:0] left_drive, [21:11] right_drive,
                                   // [22] drive_update, [23] zero fill
    output logic [2:0]  m_tuser,   // [2:0] mode_now
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    // Configuration registers.
    logic [11:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [9:0]  base_speed_reg, max_speed_reg, blind_speed_reg, turn_speed_reg;
    logic [7:0]  left_comp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= 12'd480;
            integ_gain_reg  <= 12'd0;
            deriv_gain_reg  <= 12'd80;
            base_speed_reg  <= 10'd400;
            max_speed_reg   <= 10'd800;
            blind_speed_reg <= 10'd280;
            left_comp_reg   <= 8'd20;
            turn_speed_reg  <= 10'd180;
        end else if (cfg_we) begin
            case (cfg_addr)
                lftc_pkg::REG_PROP:  prop_gain_reg   <= cfg_wdata;
                lftc_pkg::REG_INTEG: integ_gain_reg  <= cfg_wdata;
                lftc_pkg::REG_DERIV: deriv_gain_reg  <= cfg_wdata;
                lftc_pkg::REG_BASE:  base_speed_reg  <= cfg_wdata[9:0];
                lftc_pkg::REG_MAX:   max_speed_reg   <= cfg_wdata[9:0];
                lftc_pkg::REG_BLIND: blind_speed_reg <= cfg_wdata[9:0];
                lftc_pkg::REG_LCOMP: left_comp_reg   <= cfg_wdata[7:0];
                default:             turn_speed_reg  <= cfg_wdata[9:0];
            endcase
        end
    end

    // Controller state.
    lftc_pkg::seq_state_t state_reg, state_next;
    lftc_pkg::mode_t      mode_reg, mode_next;
    logic [7:0]  dwell_reg, dwell_next;
    logic [1:0]  confirm_reg, confirm_next;
    logic        pend_right_reg, pend_right_next;
    logic [6:0]  adv_cnt_reg, adv_cnt_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [11:0] last_err_reg, last_err_next;
    logic signed [15:0] integ_reg, integ_next;

    // Working registers for one tick.
    logic [7:0]  bits_reg, bits_next;
    logic signed [14:0] yaw_reg, yaw_next;
    logic [4:0]  step_reg, step_next;
    logic [11:0] quo_reg, quo_next;     // magnitude of 256*sum/count
    logic [4:0]  rem_reg, rem_next;
    logic [12:0] dividend_reg, dividend_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic signed [11:0] err_reg, err_next;
    logic signed [33:0] acc_reg, acc_next;
    logic signed [10:0] left_reg, left_next, right_reg, right_next;
    logic        upd_reg, upd_next;

    // Combinational helpers.
    logic [3:0]  black;
    logic signed [6:0] wsum;
    logic [5:0]  rem_try;
    logic signed [17:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [43:0] mul_p;
    logic signed [16:0] integ_sum;
    logic signed [16:0] yaw_s;
    logic signed [17:0] herr;
    logic signed [34:0] lim, acc_c;
    logic signed [34:0] u_full;
    logic signed [12:0] u;
    logic signed [13:0] ls, rs;
    logic signed [11:0] blind_l;

    always_comb begin
        black = '0;
        wsum  = '0;
        for (int i = 0; i < 8; i++) begin
            if (!bits_reg[i]) begin
                black = black + 4'd1;
                wsum  = wsum + 7'(lftc_pkg::line_weight(3'(i)));
            end
        end
    end

    // Shared multiplier.
    assign mul_p = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg;
        dwell_next = dwell_reg;
        confirm_next = confirm_reg;
        pend_right_next = pend_right_reg;
        adv_cnt_next = adv_cnt_reg;
        target_next = target_reg;
        last_err_next = last_err_reg;
        integ_next = integ_reg;
        bits_next = bits_reg;
        yaw_next = yaw_reg;
        step_next = step_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dividend_next = dividend_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        err_next = err_reg;
        acc_next = acc_reg;
        left_next = left_reg;
        right_next = right_reg;
        upd_next = upd_reg;
        mul_a = '0;
        mul_b = '0;
        rem_try = '0;
        integ_sum = '0;
        yaw_s = '0;
        herr = '0;
        lim = '0;
        acc_c = '0;
        u_full = '0;
        u = '0;
        ls = '0;
        rs = '0;
        blind_l = '0;
        s_tready = 1'b0;

        case (state_reg)
            lftc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    bits_next = s_tdata[7:0];
                    yaw_next = s_tdata[22:8];
                    state_next = lftc_pkg::ST_FINISH;
                end
            end
            lftc_pkg::ST_DIV: begin
                // One restoring divide step per cycle.
                rem_try = {rem_reg, dividend_reg[12]};
                dividend_next = {dividend_reg[11:0], 1'b0};
                if (rem_try >= {2'b00, cnt_reg}) begin
                    rem_next = 5'(rem_try - {2'b00, cnt_reg});
                    quo_next = {quo_reg[10:0], 1'b1};
                end else begin
                    rem_next = rem_try[4:0];
                    quo_next = {quo_reg[10:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd12) begin
                    state_next = lftc_pkg::ST_MUL_P;
                end
            end
            lftc_pkg::ST_MUL_P: begin
                err_next = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                integ_sum = 17'(integ_reg) + 17'(err_next);
                if (integ_sum > 17'sd25600) integ_next = 16'sd25600;
                else if (integ_sum < -17'sd25600) integ_next = -16'sd25600;
                else integ_next = integ_sum[15:0];
                mul_a = {6'b0, prop_gain_reg};
                mul_b = 26'(err_next);
                acc_next = 34'(mul_p);
                state_next = lftc_pkg::ST_MUL_I;
            end
            lftc_pkg::ST_MUL_I: begin
                mul_a = {6'b0, integ_gain_reg};
                mul_b = 26'(integ_reg);
                acc_next = acc_reg + 34'(mul_p);
                state_next = lftc_pkg::ST_MUL_D;
            end
            lftc_pkg::ST_MUL_D: begin
                mul_a = {6'b0, deriv_gain_reg};
                mul_b = 26'(err_reg) - 26'(last_err_reg);
                acc_next = acc_reg + 34'(mul_p);
                state_next = lftc_pkg::ST_OUT;
                step_next = 5'd1;
            end
            lftc_pkg::ST_FINISH: begin
                // Mode update for the new tick, then the per mode command.
                if (dwell_reg != 8'd255) dwell_next = dwell_reg + 8'd1;
                upd_next = 1'b1;
                left_next = '0;
                right_next = '0;
                case (mode_reg)
                    lftc_pkg::MODE_TRACK: begin
                        if (dwell_next < 8'(lftc_pkg::MIN_DWELL_TICKS)) begin
                            confirm_next = '0;
                        end else if (bits_reg[3:0] == 4'd0 && bits_reg[7:4] != 4'd0) begin
                            mode_next = lftc_pkg::MODE_ADVANCE;
                            pend_right_next = 1'b0;
                            adv_cnt_next = '0;
                            dwell_next = '0;
                            confirm_next = '0;
                        end else if (bits_reg[7:4] == 4'd0 && bits_reg[3:0] != 4'd0) begin
                            mode_next = lftc_pkg::MODE_ADVANCE;
                            pend_right_next = 1'b1;
                            adv_cnt_next = '0;
                            dwell_next = '0;
                            confirm_next = '0;
                        end else if (black == 4'd0) begin
                            if (confirm_reg != 2'd3) confirm_next = confirm_reg + 2'd1;
                            if (confirm_next >= 2'(lftc_pkg::CONFIRM_TICKS)) begin
                                mode_next = lftc_pkg::MODE_BLIND;
                                pend_right_next = 1'b0;
                                dwell_next = '0;
                                confirm_next = '0;
                            end
                        end else begin
                            confirm_next = '0;
                        end
                    end
                    lftc_pkg::MODE_BLIND: begin
                        if (dwell_next >= 8'(lftc_pkg::MIN_DWELL_TICKS) && black != 4'd0) begin
                            if (confirm_reg != 2'd3) confirm_next = confirm_reg + 2'd1;
                            if (confirm_next >= 2'(lftc_pkg::CONFIRM_TICKS)) begin
                                mode_next = lftc_pkg::MODE_TRACK;
                                last_err_next = '0;
                                integ_next = '0;
                                dwell_next = '0;
                                confirm_next = '0;
                            end
                        end else begin
                            confirm_next = '0;
                        end
                    end
                    default: ;
                endcase

                state_next = lftc_pkg::ST_OUT;
                step_next = 5'd0;
                case (mode_next)
                    lftc_pkg::MODE_TRACK: begin
                        // Start the divide of 256*|sum| by the black count.
                        cnt_next = black;
                        neg_next = wsum[6];
                        quo_next = '0;
                        rem_next = '0;
                        dividend_next = (black == 4'd0) ? 13'd0
                                        : {wsum[6] ? 5'(-wsum) : wsum[4:0], 8'd0};
                        step_next = 5'd0;
                        if (black == 4'd0) begin
                            neg_next = last_err_next[11];
                            quo_next = last_err_next[11] ? 12'(-last_err_next)
                                                         : 12'(last_err_next);
                            state_next = lftc_pkg::ST_MUL_P;
                        end else begin
                            state_next = lftc_pkg::ST_DIV;
                        end
                        // Keep the reset values for the PID when re-entering.
                    end
                    lftc_pkg::MODE_BLIND: begin
                        blind_l = -(12'(blind_speed_reg) + 12'(left_comp_reg));
                        left_next = (blind_l < -12'sd1023) ? -11'sd1023 : blind_l[10:0];
                        right_next = 11'(blind_speed_reg);
                    end
                    lftc_pkg::MODE_ADVANCE: begin
                        if (adv_cnt_next >= 7'(lftc_pkg::ADV_RUN_TICKS)) begin
                            mode_next = pend_right_next ? lftc_pkg::MODE_RIGHT
                                                        : lftc_pkg::MODE_LEFT;
                            target_next = pend_right_next
                                ? 16'(yaw_reg) - 16'(lftc_pkg::TURN_ANGLE)
                                : 16'(yaw_reg) + 16'(lftc_pkg::TURN_ANGLE);
                            dwell_next = '0;
                            confirm_next = '0;
                            upd_next = 1'b0;
                        end else begin
                            left_next = -$signed(11'(blind_speed_reg));
                            right_next = 11'(blind_speed_reg);
                            if (adv_cnt_next != 7'd127) adv_cnt_next = adv_cnt_next + 7'd1;
                        end
                    end
                    default: begin
                        // Heading error, wrapped into half a turn each way.
                        yaw_s = 17'(yaw_reg);
                        herr = 18'(target_reg) - 18'(yaw_s);
                        if (herr > 18'sd11520) herr = herr - 18'sd23040;
                        if (herr > 18'sd11520) herr = herr - 18'sd23040;
                        if (herr < -18'sd11520) herr = herr + 18'sd23040;
                        if (herr < -18'sd11520) herr = herr + 18'sd23040;
                        if (herr <= 18'(lftc_pkg::TURN_TOLERANCE)
                            && herr >= -18'(lftc_pkg::TURN_TOLERANCE)) begin
                            mode_next = lftc_pkg::MODE_BLIND;
                            pend_right_next = 1'b0;
                            dwell_next = '0;
                            confirm_next = '0;
                        end else if (mode_reg == lftc_pkg::MODE_LEFT) begin
                            left_next = -$signed(11'(turn_speed_reg));
                            right_next = -$signed(11'(turn_speed_reg));
                        end else begin
                            left_next = 11'(turn_speed_reg);
                            right_next = 11'(turn_speed_reg);
                        end
                    end
                endcase
            end
            default: begin
                // ST_OUT: step 1 ends a PID tick, then the result waits to be taken.
                if (step_reg == 5'd1) begin
                    lim = 35'($signed({1'b0, base_speed_reg})) <<< 12;
                    acc_c = 35'(acc_reg);
                    if (acc_c > lim) acc_c = lim;
                    if (acc_c < -lim) acc_c = -lim;
                    u_full = acc_c[34] ? -((-acc_c) >>> 12) : (acc_c >>> 12);
                    u = 13'(u_full);
                    ls = 14'($signed({1'b0, base_speed_reg})) - 14'(u);
                    rs = 14'($signed({1'b0, base_speed_reg})) + 14'(u);
                    if (ls < 0) ls = '0;
                    if (ls > 14'($signed({1'b0, max_speed_reg})))
                        ls = 14'($signed({1'b0, max_speed_reg}));
                    if (rs < 0) rs = '0;
                    if (rs > 14'($signed({1'b0, max_speed_reg})))
                        rs = 14'($signed({1'b0, max_speed_reg}));
                    left_next = -ls[10:0];
                    right_next = rs[10:0];
                    last_err_next = err_reg;
                    step_next = 5'd0;
                end else if (m_tready) begin
                    state_next = lftc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lftc_pkg::ST_IDLE;
            mode_reg <= lftc_pkg::MODE_TRACK;
            dwell_reg <= '0;
            confirm_reg <= '0;
            pend_right_reg <= 1'b0;
            adv_cnt_reg <= '0;
            target_reg <= '0;
            last_err_reg <= '0;
            integ_reg <= '0;
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            dwell_reg <= dwell_next;
            confirm_reg <= confirm_next;
            pend_right_reg <= pend_right_next;
            adv_cnt_reg <= adv_cnt_next;
            target_reg <= target_next;
            last_err_reg <= last_err_next;
            integ_reg <= integ_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        yaw_reg <= yaw_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dividend_reg <= dividend_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        err_reg <= err_next;
        acc_reg <= acc_next;
        left_reg <= left_next;
        right_reg <= right_next;
        upd_reg <= upd_next;
    end

    assign m_tvalid = (state_reg == lftc_pkg::ST_OUT) && (step_reg == 5'd0);
    assign m_tdata = {1'b0, upd_reg, right_reg, left_reg};
    assign m_tuser = mode_reg;

    // Checks.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != lftc_pkg::ST_IDLE) |-> !s_tready)
        else $error("request accepted while busy");
    a_integ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg <= 16'sd25600) && (integ_reg >= -16'sd25600))
        else $error("integral out of bound");
    a_confirm_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (confirm_reg != 2'd3))
        else $error("confirm count left at limit");
    a_accept_leads_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == lftc_pkg::ST_FINISH))
        else $error("accepted request not started");
    a_track_noupd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !upd_reg) |-> (left_reg == 11'sd0 && right_reg == 11'sd0))
        else $error("idle command not zero");

endmodule

// File: bench/lftc_checker.sv
// Checker for the line follow turn controller: watches both stream channels,
// predicts each motor command from a behavioral model and compares it.
// Depends on lftc_pkg for the mode and register encodings.
module lftc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic signed [10:0] left_drive;
        logic signed [10:0] right_drive;
        logic               drive_update;
        logic [2:0]         mode_now;
    } command_t;

    // Shadow configuration and controller state.
    logic [11:0] gain_p, gain_i, gain_d;
    logic [9:0]  spd_base, spd_max, spd_blind, spd_turn;
    logic [7:0]  comp_left;
    lftc_pkg::mode_t cur_mode;
    int          dwell, confirm, adv_count, heading_goal, prev_err, err_sum;
    logic        go_right;
    command_t    command_queue[$];

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void bump_confirm();
        if (confirm < 3) confirm++;
    endfunction

    function automatic void enter_advance(logic right);
        cur_mode = lftc_pkg::MODE_ADVANCE;
        go_right = right;
        adv_count = 0;
        dwell = 0;
        confirm = 0;
    endfunction

    function automatic void enter_blind();
        cur_mode = lftc_pkg::MODE_BLIND;
        go_right = 1'b0;
        dwell = 0;
        confirm = 0;
    endfunction

    // Advance the controller by one tick and return the motor command.
    function automatic command_t predict_command(logic [7:0] bits, logic signed [14:0] yaw_in);
        command_t cmd;
        int yaw, blacks, wsum, err, der, base, u, herr, ls, rs, lcmd, rcmd;
        longint acc, lim;
        yaw = yaw_in;
        blacks = 0;
        wsum = 0;
        lcmd = 0;
        rcmd = 0;
        cmd.drive_update = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (!bits[i]) begin
                blacks++;
                wsum += 2 * i - 7;
            end
        end
        if (dwell < 255) dwell++;
        // Mode machine.
        if (cur_mode == lftc_pkg::MODE_TRACK) begin
            if (dwell < lftc_pkg::MIN_DWELL_TICKS) confirm = 0;
            else if (bits[3:0] == 4'h0 && bits[7:4] != 4'h0) enter_advance(1'b0);
            else if (bits[7:4] == 4'h0 && bits[3:0] != 4'h0) enter_advance(1'b1);
            else if (blacks == 0) begin
                bump_confirm();
                if (confirm >= lftc_pkg::CONFIRM_TICKS) enter_blind();
            end else confirm = 0;
        end else if (cur_mode == lftc_pkg::MODE_BLIND) begin
            if (dwell >= lftc_pkg::MIN_DWELL_TICKS && blacks > 0) begin
                bump_confirm();
                if (confirm >= lftc_pkg::CONFIRM_TICKS) begin
                    cur_mode = lftc_pkg::MODE_TRACK;
                    prev_err = 0;
                    err_sum = 0;
                    dwell = 0;
                    confirm = 0;
                end
            end else confirm = 0;
        end
        // Motor command for the resulting mode.
        if (cur_mode == lftc_pkg::MODE_TRACK) begin
            err = (blacks == 0) ? prev_err : (wsum * 256) / blacks;
            der = err - prev_err;
            err_sum = clampi(err_sum + err, -lftc_pkg::INTEG_LIMIT, lftc_pkg::INTEG_LIMIT);
            acc = longint'(gain_p) * err + longint'(gain_i) * err_sum
                + longint'(gain_d) * der;
            base = spd_base;
            lim = longint'(base) * 4096;
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            u = int'(acc / 4096);
            prev_err = err;
            ls = clampi(base - u, 0, spd_max);
            rs = clampi(base + u, 0, spd_max);
            lcmd = -ls;
            rcmd = rs;
        end else if (cur_mode == lftc_pkg::MODE_BLIND) begin
            lcmd = -(int'(spd_blind) + int'(comp_left));
            if (lcmd < -lftc_pkg::DRIVE_LIMIT) lcmd = -lftc_pkg::DRIVE_LIMIT;
            rcmd = spd_blind;
        end else if (cur_mode == lftc_pkg::MODE_ADVANCE) begin
            if (adv_count >= lftc_pkg::ADV_RUN_TICKS) begin
                cur_mode = go_right ? lftc_pkg::MODE_RIGHT : lftc_pkg::MODE_LEFT;
                heading_goal = go_right ? yaw - lftc_pkg::TURN_ANGLE
                                        : yaw + lftc_pkg::TURN_ANGLE;
                dwell = 0;
                confirm = 0;
                cmd.drive_update = 1'b0;
            end else begin
                lcmd = -int'(spd_blind);
                rcmd = spd_blind;
                if (adv_count < 127) adv_count++;
            end
        end else begin
            herr = heading_goal - yaw;
            while (herr > lftc_pkg::DEG180) herr -= lftc_pkg::DEG360;
            while (herr < -lftc_pkg::DEG180) herr += lftc_pkg::DEG360;
            if (herr <= lftc_pkg::TURN_TOLERANCE && herr >= -lftc_pkg::TURN_TOLERANCE)
                enter_blind();
            else if (cur_mode == lftc_pkg::MODE_LEFT) begin
                lcmd = -int'(spd_turn);
                rcmd = -int'(spd_turn);
            end else begin
                lcmd = spd_turn;
                rcmd = spd_turn;
            end
        end
        cmd.left_drive = lcmd[10:0];
        cmd.right_drive = rcmd[10:0];
        cmd.mode_now = cur_mode;
        return cmd;
    endfunction

    assign pending_count = command_queue.size();

    // Register writes, requests and results, in the order of one clock edge.
    always @(posedge aclk) begin
        command_t seen, want;
        if (!aresetn) begin
            gain_p <= 12'd480; gain_i <= 12'd0; gain_d <= 12'd80;
            spd_base <= 10'd400; spd_max <= 10'd800; spd_blind <= 10'd280;
            comp_left <= 8'd20; spd_turn <= 10'd180;
            cur_mode = lftc_pkg::MODE_TRACK;
            dwell = 0; confirm = 0; adv_count = 0; heading_goal = 0;
            prev_err = 0; err_sum = 0; go_right = 1'b0;
            command_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (lftc_pkg::reg_idx_t'(cfg_addr))
                    lftc_pkg::REG_PROP:  gain_p <= cfg_wdata;
                    lftc_pkg::REG_INTEG: gain_i <= cfg_wdata;
                    lftc_pkg::REG_DERIV: gain_d <= cfg_wdata;
                    lftc_pkg::REG_BASE:  spd_base <= cfg_wdata[9:0];
                    lftc_pkg::REG_MAX:   spd_max <= cfg_wdata[9:0];
                    lftc_pkg::REG_BLIND: spd_blind <= cfg_wdata[9:0];
                    lftc_pkg::REG_LCOMP: comp_left <= cfg_wdata[7:0];
                    default:             spd_turn <= cfg_wdata[9:0];
                endcase
            end
            if (s_tvalid && s_tready)
                command_queue.push_back(predict_command(s_tdata[7:0], s_tdata[22:8]));
            if (m_tvalid && m_tready) begin
                seen.left_drive = m_tdata[10:0];
                seen.right_drive = m_tdata[21:11];
                seen.drive_update = m_tdata[22];
                seen.mode_now = m_tuser;
                if (command_queue.size() == 0) begin
                    if (fail_count < 10) $display("ERROR: motor command with none expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = command_queue.pop_front();
                    if (seen != want) begin
                        if (fail_count < 10)
                            $display({"ERROR: exp L=%0d R=%0d upd=%0b mode=%0d, ",
                                      "got L=%0d R=%0d upd=%0b mode=%0d"},
                                     want.left_drive, want.right_drive, want.drive_update,
                                     want.mode_now, seen.left_drive, seen.right_drive,
                                     seen.drive_update, seen.mode_now);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_line_follow_turn_controller.sv
// Testbench top for the line follow turn controller: makes clock, reset,
// register writes and sensor ticks; the lftc_checker module does the checking.
// Depends on lftc_pkg, the block and lftc_checker.
module tb_line_follow_turn_controller;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    int          fail_count, pending_count;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    line_follow_turn_controller u_top (.*);
    lftc_checker u_check (.*);

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Write one register; the enable stays high until end_writes.
    task automatic write_reg(lftc_pkg::reg_idx_t idx, int value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value[11:0];
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    // Send one tick request, with random idle cycles before it. The valid
    // stays high after acceptance until the next call or drain drops it.
    task automatic send_tick(logic [7:0] bits, logic [14:0] yaw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, yaw, bits};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [14:0] rand_yaw();
        return 15'($urandom_range(23039) - 11520);
    endfunction

    // Sequence driving the mode machine: track dwell, edge pattern or all
    // white, advance, turn sweep, blind, back to track.
    task automatic run_scenario();
        int yaw, n;
        logic [7:0] edge_bits;
        yaw = $urandom_range(23039) - 11520;
        n = 95 + $urandom_range(10);
        for (int i = 0; i < n; i++) send_tick(8'($urandom), 15'(yaw));
        case ($urandom_range(2))
            0: edge_bits = {4'($urandom_range(1, 15)), 4'h0};
            1: edge_bits = {4'h0, 4'($urandom_range(1, 15))};
            default: edge_bits = 8'hFF;
        endcase
        for (int i = 0; i < 4; i++) send_tick(edge_bits, 15'(yaw));
        for (int i = 0; i < 84; i++) send_tick(8'($urandom), 15'(yaw));
        // Sweep the heading around in big steps so the turn can end.
        for (int i = 0; i < 40; i++) begin
            yaw = yaw + (($urandom_range(1)) ? 600 : -600);
            if (yaw > 16383) yaw -= 23040;
            if (yaw < -16384) yaw += 23040;
            send_tick(8'($urandom), 15'(yaw));
        end
        for (int i = 0; i < 110; i++)
            send_tick(($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF, rand_yaw());
    endtask

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: sensor extremes, single blacks, out-of-range yaw.
        send_tick(8'h00, 15'h3FFF);
        send_tick(8'hFF, 15'h4000);
        send_tick(8'hFE, 15'd0);
        send_tick(8'h7F, 15'd0);
        send_tick(8'hE7, 15'h7FFF);
        send_tick(8'h0F, 15'd11519);
        send_tick(8'hF0, -15'sd11520);
        send_tick(8'hAA, 15'd100);
        send_tick(8'h55, 15'd200);
        drain();
        // Extreme gains and speeds; blind overflow comes with these.
        write_reg(lftc_pkg::REG_PROP, 4095);
        write_reg(lftc_pkg::REG_INTEG, 4095);
        write_reg(lftc_pkg::REG_DERIV, 4095);
        write_reg(lftc_pkg::REG_BASE, 1000);
        write_reg(lftc_pkg::REG_MAX, 1023);
        write_reg(lftc_pkg::REG_BLIND, 1000);
        write_reg(lftc_pkg::REG_LCOMP, 255);
        write_reg(lftc_pkg::REG_TURN, 1023);
        end_writes();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            run_scenario();
            drain();
            // New random settings, lowest values in one phase.
            write_reg(lftc_pkg::REG_PROP, (p == 0) ? 0 : $urandom_range(4095));
            write_reg(lftc_pkg::REG_INTEG, (p == 0) ? 0 : $urandom_range(60));
            write_reg(lftc_pkg::REG_DERIV, (p == 0) ? 0 : $urandom_range(4095));
            write_reg(lftc_pkg::REG_BASE, (p == 0) ? 0 : $urandom_range(1000));
            write_reg(lftc_pkg::REG_MAX, (p == 0) ? 0 : $urandom_range(1000));
            write_reg(lftc_pkg::REG_BLIND, $urandom_range(1000));
            write_reg(lftc_pkg::REG_LCOMP, $urandom_range(255));
            write_reg(lftc_pkg::REG_TURN, $urandom_range(1000));
            end_writes();
        end
        // Long receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_tick(8'($urandom), rand_yaw());
        join
        recv_stall_pct = 20;
        for (int i = 0; i < 620; i++) send_tick(8'($urandom), 15'($urandom));
        drain();
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
